// ===== hw/rtl/dtp_pkg.sv =====
// Shared types and constants for the device tree token parser.
// Holds beat structs, token codes, event codes and the blob magic word.
// No dependencies.
package dtp_pkg;

  // Blob header magic word.
  localparam logic [31:0] DT_MAGIC = 32'hD00D_FEED;

  // Structure block token codes.
  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  // Result event codes.
  localparam logic [1:0] EV_PROP      = 2'd0;
  localparam logic [1:0] EV_BAD_MAGIC = 2'd1;
  localparam logic [1:0] EV_UNKNOWN   = 2'd2;
  localparam logic [1:0] EV_FINISHED  = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [31:0] blob_word;
    logic        blob_start;
  } dtp_in_t;

  // Result beat.
  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] name_position;
    logic [31:0] value_length;
    logic [31:0] first_value;
    logic        last_of_run;
  } dtp_res_t;

  // Results produced by one input beat, in order: res0 first.
  typedef struct packed {
    logic [1:0] cnt;
    dtp_res_t   res0;
    dtp_res_t   res1;
  } dtp_push_t;

endpackage

// ===== hw/rtl/dtp_walker.sv =====
// Token walker: header capture, structure block walk and event generation.
// Consumes one registered input beat per step. Depends on dtp_pkg.
module dtp_walker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  dtp_pkg::dtp_in_t beat,
  output dtp_pkg::dtp_push_t push
);
  import dtp_pkg::*;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_HEADER = 3'd1;
  localparam logic [2:0] MODE_TOKEN  = 3'd2;
  localparam logic [2:0] MODE_NAME   = 3'd3;
  localparam logic [2:0] MODE_PLEN   = 3'd4;
  localparam logic [2:0] MODE_PNAME  = 3'd5;
  localparam logic [2:0] MODE_VALUE  = 3'd6;

  localparam logic [31:0] FIRST_TOKEN_WORD = 32'd10;

  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] word_index_r, word_index_nxt;
  logic [31:0] begin_word_r, begin_word_nxt;
  logic [32:0] struct_end_r, struct_end_nxt;
  logic [31:0] strings_start_r, strings_start_nxt;
  logic [31:0] pending_length_r, pending_length_nxt;
  logic [31:0] pending_name_r, pending_name_nxt;
  logic [29:0] words_left_r, words_left_nxt;
  logic        first_value_r, first_value_nxt;

  logic [31:0] w;
  logic        halted;
  logic        ev_valid;
  dtp_res_t    ev;
  logic        fin;
  logic [30:0] value_words;
  logic [29:0] left_dec;
  logic [31:0] begin_cand;

  assign w           = beat.blob_word;
  assign value_words = 31'(({1'b0, pending_length_r} + 33'd3) >> 2);
  assign left_dec    = words_left_r - 30'd1;
  assign begin_cand  = ({2'b00, w[31:2]} < FIRST_TOKEN_WORD) ? FIRST_TOKEN_WORD
                                                              : {2'b00, w[31:2]};

  // Next state and the primary event of this beat.
  always_comb begin
    mode_nxt           = mode_r;
    word_index_nxt     = word_index_r;
    begin_word_nxt     = begin_word_r;
    struct_end_nxt     = struct_end_r;
    strings_start_nxt  = strings_start_r;
    pending_length_nxt = pending_length_r;
    pending_name_nxt   = pending_name_r;
    words_left_nxt     = words_left_r;
    first_value_nxt    = first_value_r;
    halted             = 1'b0;
    ev_valid           = 1'b0;
    ev                 = '0;
    fin                = 1'b0;

    if (beat.blob_start) begin
      // A start beat abandons any walk and checks the magic word.
      word_index_nxt     = '0;
      begin_word_nxt     = FIRST_TOKEN_WORD;
      struct_end_nxt     = '0;
      strings_start_nxt  = '0;
      pending_length_nxt = '0;
      pending_name_nxt   = '0;
      words_left_nxt     = '0;
      first_value_nxt    = 1'b0;
      if (w != DT_MAGIC) begin
        ev_valid     = 1'b1;
        ev.event_res = EV_BAD_MAGIC;
        mode_nxt     = MODE_IDLE;
      end else begin
        mode_nxt = MODE_HEADER;
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          halted = 1'b1;
        end
        MODE_HEADER: begin
          // The end address is built from the offset first, then the size.
          if (word_index_r == 32'd2) begin
            begin_word_nxt = begin_cand;
            struct_end_nxt = {1'b0, w};
          end else if (word_index_r == 32'd3) begin
            strings_start_nxt = w;
          end else if (word_index_r == 32'd9) begin
            struct_end_nxt = struct_end_r + {1'b0, w};
            mode_nxt       = MODE_TOKEN;
          end
        end
        MODE_TOKEN: begin
          if (word_index_r >= begin_word_r) begin
            unique case (w) inside
              TOK_BEGIN_NODE: mode_nxt = MODE_NAME;
              TOK_PROP:       mode_nxt = MODE_PLEN;
              TOK_END_NODE, TOK_NOP, TOK_END: ;
              default: begin
                ev_valid     = 1'b1;
                ev.event_res = EV_UNKNOWN;
                mode_nxt     = MODE_IDLE;
              end
            endcase
          end
        end
        MODE_NAME: begin
          // The name ends with the first word that holds a zero byte.
          if ((w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
              (w[15:8] == 8'd0) || (w[7:0] == 8'd0)) begin
            mode_nxt = MODE_TOKEN;
          end
        end
        MODE_PLEN: begin
          pending_length_nxt = w;
          mode_nxt           = MODE_PNAME;
        end
        MODE_PNAME: begin
          pending_name_nxt = strings_start_r + w;
          if (pending_length_r == 32'd0) begin
            ev_valid         = 1'b1;
            ev.event_res     = EV_PROP;
            ev.name_position = strings_start_r + w;
            mode_nxt         = MODE_TOKEN;
          end else begin
            first_value_nxt = 1'b1;
            mode_nxt        = MODE_VALUE;
          end
        end
        MODE_VALUE: begin
          if (first_value_r) begin
            // First value word: report the property, then skip the remaining value words and padding.
            ev_valid         = 1'b1;
            ev.event_res     = EV_PROP;
            ev.name_position = pending_name_r;
            ev.value_length  = pending_length_r;
            ev.first_value   = w;
            first_value_nxt  = 1'b0;
            words_left_nxt   = 30'(value_words - 31'd1);
            if (value_words == 31'd1) begin
              mode_nxt = MODE_TOKEN;
            end
          end else begin
            if (words_left_r != 30'd0) begin
              words_left_nxt = left_dec;
            end
            if ((words_left_r == 30'd0) || (left_dec == 30'd0)) begin
              mode_nxt = MODE_TOKEN;
            end
          end
        end
        default: begin
          halted = 1'b1;
        end
      endcase
    end

    // Word counter, saturating; idle beats without start do not count.
    if (!halted) begin
      if (beat.blob_start) begin
        word_index_nxt = 32'd1;
      end else if (word_index_r != '1) begin
        word_index_nxt = word_index_r + 32'd1;
      end
    end

    // End of structure block is tested at token boundaries only.
    if (!halted && (mode_nxt == MODE_TOKEN) && (word_index_nxt >= begin_word_nxt) &&
        ({word_index_nxt, 2'b00} >= {1'b0, struct_end_nxt})) begin
      fin      = 1'b1;
      mode_nxt = MODE_IDLE;
    end
  end

  // Pack this beat's results in order.
  always_comb begin
    push = '0;
    if (step) begin
      if (ev_valid && fin) begin
        push.cnt                 = 2'd2;
        push.res0                = ev;
        push.res1.event_res      = EV_FINISHED;
        push.res1.last_of_run    = 1'b1;
      end else if (ev_valid) begin
        push.cnt                 = 2'd1;
        push.res0                = ev;
        push.res0.last_of_run    = 1'b1;
      end else if (fin) begin
        push.cnt                 = 2'd1;
        push.res0.event_res      = EV_FINISHED;
        push.res0.last_of_run    = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_IDLE;
      word_index_r     <= '0;
      begin_word_r     <= FIRST_TOKEN_WORD;
      struct_end_r     <= '0;
      strings_start_r  <= '0;
      pending_length_r <= '0;
      pending_name_r   <= '0;
      words_left_r     <= '0;
      first_value_r    <= 1'b0;
    end else if (step) begin
      mode_r           <= mode_nxt;
      word_index_r     <= word_index_nxt;
      begin_word_r     <= begin_word_nxt;
      struct_end_r     <= struct_end_nxt;
      strings_start_r  <= strings_start_nxt;
      pending_length_r <= pending_length_nxt;
      pending_name_r   <= pending_name_nxt;
      words_left_r     <= words_left_nxt;
      first_value_r    <= first_value_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Two results in one beat are always a property followed by the finish.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (push.res0.event_res == EV_PROP) &&
                           (push.res1.event_res == EV_FINISHED))
    else $error("dtp_walker: bad pair of results");

  // No results without a step.
  assert property (@(posedge clk) disable iff (!rst_n)
    !step |-> (push.cnt == 2'd0))
    else $error("dtp_walker: results without a step");

  // A bad magic word leaves the walker idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (step && beat.blob_start && (beat.blob_word != DT_MAGIC)) |=> (mode_r == MODE_IDLE))
    else $error("dtp_walker: not idle after bad magic");

  // The first value flag is only set while in the value mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    first_value_r |-> (mode_r == MODE_VALUE))
    else $error("dtp_walker: first value flag outside value mode");
`endif

endmodule

// ===== hw/rtl/dtp_result_fifo.sv =====
// Result queue: takes up to two result beats per cycle, hands out one unless stalled.
// Entries are flops read at the head pointer. Depends on dtp_pkg.
module dtp_result_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dtp_pkg::dtp_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output dtp_pkg::dtp_res_t  out_data
);
  import dtp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dtp_res_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_ptr1;
  logic [PW-1:0]   wr_ptr2;
  logic            pop;

  assign wr_ptr1   = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign wr_ptr2   = (wr_ptr1 == PW'(DEPTH - 1)) ? '0 : wr_ptr1 + PW'(1);
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= CW'(DEPTH - 2));

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.cnt == 2'd1) begin
      wr_ptr_nxt = wr_ptr1;
    end else if (push.cnt == 2'd2) begin
      wr_ptr_nxt = wr_ptr2;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes, one or two per cycle; each entry takes at most one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if ((push.cnt != 2'd0) && (wr_ptr_r == PW'(i))) begin
        mem_r[i] <= push.res0;
      end else if ((push.cnt == 2'd2) && (wr_ptr1 == PW'(i))) begin
        mem_r[i] <= push.res1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("dtp_result_fifo: overflow");

  // Pushes only arrive while two entries are free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> $past(room) || room)
    else $error("dtp_result_fifo: push without room");

  // A stalled head entry stays in place.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(rd_ptr_r))
    else $error("dtp_result_fifo: head moved under stall");
`endif

endmodule

// ===== hw/rtl/device_tree_token_parser.sv =====
// Top level of the device tree token parser.
// Instantiates dtp_walker and dtp_result_fifo. Depends on dtp_pkg.

// The parser takes one 32-bit blob word per beat and can accept a beat in
// every cycle. An accepted beat is held in an input register and processed
// once the queue has two free entries; its results (none, one or two) enter
// a result queue of RES_DEPTH entries. The input stalls while a beat is held
// and the queue has fewer than two free entries; with a sink that takes a
// beat in every cycle the rate is one word per cycle. A beat with blob_start
// high restarts the parser at word zero, whatever it was doing. RES_DEPTH
// must be at least 2.
module device_tree_token_parser #(
  parameter int RES_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dtp_pkg::dtp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dtp_pkg::dtp_res_t out_data
);
  import dtp_pkg::*;

  logic      in_valid_r;
  dtp_in_t   in_data_r;
  logic      room;
  logic      step;
  dtp_push_t push;

  // The held beat advances when the queue can take two results.
  assign step     = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  dtp_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .beat  (in_data_r),
    .push  (push)
  );

  dtp_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
